// ----- hdl/uvs_pkg.sv -----
`default_nettype none

package uvs_pkg;

	// Stack geometry
	localparam int DEPTH = 16;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 32;
	localparam int DEPTH_OUT_W = 5;

	// Command codes
	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_POP   = 2'd1;
	localparam logic [1:0] CMD_PEEK  = 2'd2;
	localparam logic [1:0] CMD_QUERY = 2'd3;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_DUP   = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	// Shift control broadcast to every cell
	typedef struct packed {
		logic push;
		logic pop;
	} shift_ctl_t;

endpackage

`default_nettype wire

// ----- hdl/unique_value_stack.sv -----
// LIFO stack of 32-bit signed values (DEPTH entries) that refuses duplicate pushes.
// Commands: push, pop, peek and membership query; every accepted beat produces
// exactly one result beat carrying the top value, depth, empty flag, found flag
// and status. One command is taken per clock cycle: the stack is a row of cells
// that shift together on push or pop, and every cell compares its entry with the
// incoming value in the same cycle, so the result is ready in the cycle after the input
// beat is accepted. The result sits in an output register; a new command is
// accepted whenever that register is empty or is being drained in the same cycle.
`default_nettype none

module unique_value_stack (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [1:0]                           cmd,
	input  wire logic signed [uvs_pkg::VAL_W-1:0]     value,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic signed [uvs_pkg::VAL_W-1:0]          top_value,
	output logic      [uvs_pkg::DEPTH_OUT_W-1:0]      depth,
	output logic                                      is_empty,
	output logic                                      found,
	output logic      [1:0]                           status
);
	import uvs_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] top_q;
	logic [DEPTH_OUT_W-1:0] depth_q;
	logic             empty_q;
	logic             found_q;
	logic [1:0]       status_q;

	logic             in_fire;
	logic [VAL_W-1:0] cell_data [DEPTH];
	logic [DEPTH-1:0] cell_hit;
	logic             any_hit;
	logic             full;
	logic             empty;
	logic [1:0]       st_n;
	logic [CNT_W-1:0] count_n;
	shift_ctl_t       ctl_raw;
	shift_ctl_t       ctl;
	logic [VAL_W-1:0] top_n;
	logic [CNT_W+DEPTH_OUT_W-1:0] depth_ext;

	assign in_fire  = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;

	// Row of cells, cell 0 holds the top of stack
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [VAL_W-1:0] above_i;
		logic [VAL_W-1:0] below_i;
		if (i == 0) begin : g_first
			assign above_i = VAL_W'(value);
		end else begin : g_mid_a
			assign above_i = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign below_i = '0;
		end else begin : g_mid_b
			assign below_i = cell_data[i+1];
		end
		uvs_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.above (above_i),
			.below (below_i),
			.key   (VAL_W'(value)),
			.occ   (count_q > CNT_W'(i)),
			.data  (cell_data[i]),
			.hit   (cell_hit[i])
		);
	end

	assign any_hit = |cell_hit;
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);

	// Command decode
	always_comb begin
		st_n    = ST_OK;
		count_n = count_q;
		ctl_raw = '0;
		unique case (cmd)
			CMD_PUSH: begin
				if (any_hit) begin
					st_n = ST_DUP;
				end else if (full) begin
					st_n = ST_FULL;
				end else begin
					ctl_raw.push = 1'b1;
					count_n      = count_q + CNT_W'(1);
				end
			end
			CMD_POP: begin
				if (empty) begin
					st_n = ST_EMPTY;
				end else begin
					ctl_raw.pop = 1'b1;
					count_n     = count_q - CNT_W'(1);
				end
			end
			CMD_PEEK: begin
				if (empty) begin
					st_n = ST_EMPTY;
				end
			end
			CMD_QUERY: begin
				st_n = ST_OK;
			end
			default: begin
				st_n = ST_OK;
			end
		endcase
	end

	assign ctl.push = ctl_raw.push && in_fire;
	assign ctl.pop  = ctl_raw.pop && in_fire;

	// Top of stack after the step
	always_comb begin
		if (count_n == '0) begin
			top_n = '0;
		end else if (ctl_raw.push) begin
			top_n = VAL_W'(value);
		end else if (ctl_raw.pop) begin
			top_n = cell_data[1];
		end else begin
			top_n = cell_data[0];
		end
	end

	// Depth field keeps the low bits of the count
	assign depth_ext = {{DEPTH_OUT_W{1'b0}}, count_n};

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				count_q <= count_n;
			end
			if (in_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (in_fire) begin
			top_q    <= top_n;
			depth_q  <= depth_ext[DEPTH_OUT_W-1:0];
			empty_q  <= (count_n == '0);
			found_q  <= any_hit;
			status_q <= st_n;
		end
	end

	assign out_valid = out_valid_q;
	assign top_value = top_q;
	assign depth     = depth_q;
	assign is_empty  = empty_q;
	assign found     = found_q;
	assign status    = status_q;

	// Checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("count exceeds stack depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && cmd == CMD_PUSH && !any_hit && !full |=>
		count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted push did not grow the stack");

	a_dup_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q == ST_DUP |-> found_q)
		else $error("duplicate status without found flag");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> empty_q == (count_q == '0))
		else $error("empty flag disagrees with count");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && cmd == CMD_POP && empty |=> count_q == '0)
		else $error("pop on empty stack changed the count");

endmodule

`default_nettype wire

// ----- hdl/uvs_cell.sv -----
`default_nettype none

module uvs_cell (
	input  wire logic                       clk,
	input  wire uvs_pkg::shift_ctl_t        ctl,
	input  wire logic [uvs_pkg::VAL_W-1:0]  above,
	input  wire logic [uvs_pkg::VAL_W-1:0]  below,
	input  wire logic [uvs_pkg::VAL_W-1:0]  key,
	input  wire logic                       occ,
	output logic      [uvs_pkg::VAL_W-1:0]  data,
	output logic                            hit
);
	import uvs_pkg::*;

	logic [VAL_W-1:0] data_q;

	// Push moves entries one cell deeper, pop moves them one cell toward the top
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			data_q <= above;
		end else if (ctl.pop) begin
			data_q <= below;
		end
	end

	// Local match, only for occupied cells
	assign hit  = occ && (data_q == key);
	assign data = data_q;

endmodule

`default_nettype wire
